### rtl/core/gpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and target-angle table for the gait PD controller.
// Depends on nothing; every other file of the block imports it.
package gpd_pkg;

	// Field and datapath widths.
	localparam int KIND_W     = 2;
	localparam int TIME_W     = 20;
	localparam int JOINT_W    = 3;
	localparam int ANGLE_W    = 16;
	localparam int RATE_W     = 16;
	localparam int FOOT_W     = 2;
	localparam int GAIN_W     = 12;
	localparam int ACC_W      = 22;
	localparam int PHASE_W    = 2;
	localparam int DIFF_W     = ANGLE_W + 1;
	localparam int TORQUE_W   = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_JOINT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONTACT = 2'd2;

	// Contact foot codes.
	localparam logic [FOOT_W-1:0] FOOT_LEFT  = 2'd1;
	localparam logic [FOOT_W-1:0] FOOT_RIGHT = 2'd2;

	// Highest valid joint, first ankle joint and first knee joint.
	localparam logic [JOINT_W-1:0] JOINT_LAST  = 3'd5;
	localparam logic [JOINT_W-1:0] JOINT_ANKLE = 3'd4;
	localparam logic [JOINT_W-1:0] JOINT_KNEE  = 3'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HK_STIFF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HK_DAMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANK_STIFF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANK_DAMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd4;

	// Register reset values.
	localparam logic [GAIN_W-1:0] RST_HK_STIFF  = 12'd2000;
	localparam logic [GAIN_W-1:0] RST_HK_DAMP   = 12'd200;
	localparam logic [GAIN_W-1:0] RST_ANK_STIFF = 12'd500;
	localparam logic [GAIN_W-1:0] RST_ANK_DAMP  = 12'd50;
	localparam logic [TIME_W-1:0] RST_STEP      = 20'd800000;

	// Saturation value of the time accumulator.
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Target angles in Q3.12, rounded to nearest.
	localparam logic signed [ANGLE_W-1:0] TGT_M0P5 = -16'sd2048;
	localparam logic signed [ANGLE_W-1:0] TGT_M0P4 = -16'sd1638;
	localparam logic signed [ANGLE_W-1:0] TGT_P0P2 = 16'sd819;
	localparam logic signed [ANGLE_W-1:0] TGT_P0P3 = 16'sd1229;
	localparam logic signed [ANGLE_W-1:0] TGT_P0P5 = 16'sd2048;
	localparam logic signed [ANGLE_W-1:0] TGT_P1P5 = 16'sd6144;

	// One joint sample on its way from the front to the back.
	typedef struct packed {
		logic [JOINT_W-1:0]        joint;
		logic signed [DIFF_W-1:0]  diff;
		logic signed [RATE_W-1:0]  rate;
		logic [GAIN_W-1:0]         k;
		logic [GAIN_W-1:0]         d;
		logic [PHASE_W-1:0]        phase;
		logic                      started;
	} entry_t;

	// Target angle for a joint in the given phase; zero before the first tick.
	function automatic logic signed [ANGLE_W-1:0] target_for(
		input logic [PHASE_W-1:0] phase,
		input logic               valid,
		input logic [JOINT_W-1:0] joint
	);
		logic lead_leg;
		logic is_lead;
		logic mid_step;
		logic signed [ANGLE_W-1:0] t;
		lead_leg = phase[1];
		is_lead  = (joint[0] == lead_leg);
		// Phases 1 and 2 use the mid-step hip angles.
		mid_step = (phase[1] != phase[0]);
		if (!valid) begin
			t = '0;
		end else if (joint < JOINT_KNEE) begin
			if (is_lead) begin
				t = mid_step ? TGT_M0P4 : TGT_M0P5;
			end else begin
				t = mid_step ? TGT_P0P3 : TGT_P0P2;
			end
		end else if (joint < JOINT_ANKLE) begin
			t = is_lead ? TGT_P1P5 : TGT_P0P5;
		end else begin
			t = TGT_M0P5;
		end
		return t;
	endfunction

endpackage

### rtl/core/biped_gait_pd_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the gait PD controller: front, entry queue and back.
// Depends on gpd_pkg, gpd_front, gpd_queue and gpd_back.
//
// Takes one item per clock unless full: ticks and foot contacts update the four-phase
// gait state in the cycle they are accepted, and a joint sample (joints 0 to 5)
// yields one PD torque result. A sample's result passes through the queue and the two
// back stages (gain multiplies, then combine and clamp) before it reaches the result
// ports. Samples wait in a Q_DEPTH-entry queue, so full rises only after the result
// side has stalled long enough to fill the queue and both back stages. Configuration
// writes take effect at the next clock edge and are meant for an idle block.
module biped_gait_pd_controller_unit import gpd_pkg::*; #(
	parameter int Q_DEPTH = QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [KIND_W-1:0]         kind,
	input  logic [TIME_W-1:0]         elapsed_us,
	input  logic [JOINT_W-1:0]        joint_select,
	input  logic signed [ANGLE_W-1:0] joint_angle,
	input  logic signed [RATE_W-1:0]  joint_rate,
	input  logic [FOOT_W-1:0]         contact_foot,
	output logic                      empty,
	input  logic                      pop,
	output logic [JOINT_W-1:0]        joint_out,
	output logic signed [TORQUE_W-1:0] torque,
	output logic [PHASE_W-1:0]        gait_phase_out,
	output logic                      gait_started,
	input  logic                      cfg_wen,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

	logic   q_push;
	entry_t q_wr_entry;
	logic   q_full;
	logic   q_pop;
	entry_t q_rd_entry;
	logic   q_valid;

	assign full = q_full;

	gpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.kind         (kind),
		.elapsed_us   (elapsed_us),
		.joint_select (joint_select),
		.joint_angle  (joint_angle),
		.joint_rate   (joint_rate),
		.contact_foot (contact_foot),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.q_push       (q_push),
		.q_entry      (q_wr_entry)
	);

	gpd_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_data  (q_wr_entry),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_data  (q_rd_entry),
		.rd_valid (q_valid)
	);

	gpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_entry        (q_rd_entry),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.joint_out      (joint_out),
		.torque         (torque),
		.gait_phase_out (gait_phase_out),
		.gait_started   (gait_started)
	);

endmodule

### rtl/core/gpd_front.sv
`timescale 1ns / 1ps
// Front part of the gait PD controller: configuration registers, gait state machine,
// and classification of joint samples into queue entries. Depends on gpd_pkg.
module gpd_front import gpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   q_full,
	input  logic [KIND_W-1:0]      kind,
	input  logic [TIME_W-1:0]      elapsed_us,
	input  logic [JOINT_W-1:0]     joint_select,
	input  logic signed [ANGLE_W-1:0] joint_angle,
	input  logic signed [RATE_W-1:0]  joint_rate,
	input  logic [FOOT_W-1:0]      contact_foot,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output logic                   q_push,
	output entry_t                 q_entry
);

	logic [GAIN_W-1:0]  hk_stiff_q;
	logic [GAIN_W-1:0]  hk_damp_q;
	logic [GAIN_W-1:0]  ank_stiff_q;
	logic [GAIN_W-1:0]  ank_damp_q;
	logic [TIME_W-1:0]  step_q;

	logic [PHASE_W-1:0] phase_q;
	logic               valid_q;
	logic [PHASE_W-1:0] pend_q;
	logic [ACC_W-1:0]   acc_q;

	logic [PHASE_W-1:0] phase_d;
	logic               valid_d;
	logic [PHASE_W-1:0] pend_d;
	logic [ACC_W-1:0]   acc_d;

	logic               accept;
	logic [ACC_W:0]     sum_raw;
	logic [ACC_W-1:0]   sum_sat;
	logic [ACC_W-1:0]   step_ext;
	logic               step_done;
	logic [ACC_W-1:0]   sum_new;
	logic               is_ankle;
	logic signed [ANGLE_W-1:0] target;

	assign accept = push && !q_full;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hk_stiff_q  <= RST_HK_STIFF;
			hk_damp_q   <= RST_HK_DAMP;
			ank_stiff_q <= RST_ANK_STIFF;
			ank_damp_q  <= RST_ANK_DAMP;
			step_q      <= RST_STEP;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_HK_STIFF:  hk_stiff_q  <= cfg_wdata[GAIN_W-1:0];
				REG_HK_DAMP:   hk_damp_q   <= cfg_wdata[GAIN_W-1:0];
				REG_ANK_STIFF: ank_stiff_q <= cfg_wdata[GAIN_W-1:0];
				REG_ANK_DAMP:  ank_damp_q  <= cfg_wdata[GAIN_W-1:0];
				REG_STEP:      step_q      <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating time sum and the step interval compare.
	assign sum_raw   = {1'b0, acc_q} + {{(ACC_W + 1 - TIME_W){1'b0}}, elapsed_us};
	assign sum_sat   = sum_raw[ACC_W] ? ACC_MAX : sum_raw[ACC_W-1:0];
	assign step_ext  = {{(ACC_W - TIME_W){1'b0}}, step_q};
	assign step_done = (sum_sat > step_ext);
	assign sum_new   = step_done ? (sum_sat - step_ext) : sum_sat;

	// Next gait state for ticks and contacts.
	always_comb begin
		phase_d = phase_q;
		valid_d = valid_q;
		pend_d  = pend_q;
		acc_d   = acc_q;
		if (accept) begin
			case (kind)
				KIND_TICK: begin
					if (valid_q && !phase_q[0]) begin
						acc_d = sum_new;
						if (step_done) begin
							pend_d = phase_q + 2'd1;
						end
					end
					if (!valid_q || (pend_d != phase_q)) begin
						phase_d = pend_d;
						valid_d = 1'b1;
					end
				end
				KIND_CONTACT: begin
					if (valid_q) begin
						if ((phase_q == 2'd1) && (contact_foot == FOOT_LEFT)) begin
							pend_d = 2'd2;
						end else if ((phase_q == 2'd3) && (contact_foot == FOOT_RIGHT)) begin
							pend_d = 2'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_q <= 1'b0;
			pend_q  <= '0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			valid_q <= valid_d;
			pend_q  <= pend_d;
			acc_q   <= acc_d;
		end
	end

	// Joint samples: pick gains and target, form the angle error.
	assign is_ankle = (joint_select >= JOINT_ANKLE);
	assign target   = target_for(phase_q, valid_q, joint_select);

	assign q_push = accept && (kind == KIND_JOINT) && (joint_select <= JOINT_LAST);

	always_comb begin
		q_entry.joint   = joint_select;
		q_entry.diff    = {target[ANGLE_W-1], target} - {joint_angle[ANGLE_W-1], joint_angle};
		q_entry.rate    = joint_rate;
		q_entry.k       = is_ankle ? ank_stiff_q : hk_stiff_q;
		q_entry.d       = is_ankle ? ank_damp_q : hk_damp_q;
		q_entry.phase   = phase_q;
		q_entry.started = valid_q;
	end

endmodule

### rtl/core/gpd_queue.sv
`timescale 1ns / 1ps
// Short queue of joint-sample entries between the front and the back.
// Depends on gpd_pkg for the entry type.
module gpd_queue import gpd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   rd_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/gpd_back.sv
`timescale 1ns / 1ps
// Back part of the gait PD controller: two gain multiplies, then combine and clamp
// into the result register. Depends on gpd_pkg.
module gpd_back import gpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  entry_t                 q_entry,
	output logic                   q_pop,
	input  logic                   pop,
	output logic                   empty,
	output logic [JOINT_W-1:0]     joint_out,
	output logic signed [TORQUE_W-1:0] torque,
	output logic [PHASE_W-1:0]     gait_phase_out,
	output logic                   gait_started
);

	localparam int KP_W = GAIN_W + 1 + DIFF_W;
	localparam int KD_W = GAIN_W + 1 + RATE_W;
	localparam int TQ_W = KD_W + 6;

	logic                     adv_s1;
	logic                     adv_s2;
	logic signed [KP_W-1:0]   k_ext;
	logic signed [KP_W-1:0]   diff_ext;
	logic signed [KD_W-1:0]   d_ext;
	logic signed [KD_W-1:0]   rate_ext;

	logic                     v_s1;
	logic signed [KP_W-1:0]   kp_s1;
	logic signed [KD_W-1:0]   kd_s1;
	logic [GAIN_W-1:0]        k_s1;
	logic [JOINT_W-1:0]       joint_s1;
	logic [PHASE_W-1:0]       phase_s1;
	logic                     started_s1;

	logic signed [TQ_W-1:0]   tq_raw;
	logic signed [TQ_W-1:0]   lim;
	logic signed [TQ_W-1:0]   tq_clamp;

	logic                     v_s2;
	logic signed [TORQUE_W-1:0] torque_s2;
	logic [JOINT_W-1:0]       joint_s2;
	logic [PHASE_W-1:0]       phase_s2;
	logic                     started_s2;

	// Stall chain: each stage moves when the one after it is free or moving.
	assign adv_s2 = !v_s2 || pop;
	assign adv_s1 = !v_s1 || adv_s2;
	assign q_pop  = q_valid && adv_s1;

	// Stage 1 operands: gains zero-extended, error and rate sign-extended to the product widths.
	assign k_ext    = KP_W'($signed({1'b0, q_entry.k}));
	assign diff_ext = KP_W'(q_entry.diff);
	assign d_ext    = KD_W'($signed({1'b0, q_entry.d}));
	assign rate_ext = KD_W'(q_entry.rate);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kp_s1      <= k_ext * diff_ext;
			kd_s1      <= d_ext * rate_ext;
			k_s1       <= q_entry.k;
			joint_s1   <= q_entry.joint;
			phase_s1   <= q_entry.phase;
			started_s1 <= q_entry.started;
		end
	end

	// Stage 2: proportional minus damping term, clamped to the stiffness limit.
	assign tq_raw = TQ_W'(kp_s1) - (TQ_W'(kd_s1) <<< 4);
	assign lim    = TQ_W'($signed({1'b0, k_s1, 12'b0}));

	always_comb begin
		if (tq_raw > lim) begin
			tq_clamp = lim;
		end else if (tq_raw < -lim) begin
			tq_clamp = -lim;
		end else begin
			tq_clamp = tq_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			torque_s2  <= tq_clamp[TORQUE_W-1:0];
			joint_s2   <= joint_s1;
			phase_s2   <= phase_s1;
			started_s2 <= started_s1;
		end
	end

	assign empty          = !v_s2;
	assign joint_out      = joint_s2;
	assign torque         = torque_s2;
	assign gait_phase_out = phase_s2;
	assign gait_started   = started_s2;

endmodule

### rtl/core/gpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the gait PD controller and the bind that attaches them.
// Depends on gpd_pkg and biped_gait_pd_controller_unit.
module gpd_checker import gpd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input logic                      empty,
	input logic                      pop,
	input logic [JOINT_W-1:0]        joint_out,
	input logic signed [TORQUE_W-1:0] torque,
	input logic [PHASE_W-1:0]        gait_phase_out,
	input logic                      gait_started
);

	// A waiting result beat holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(torque) && $stable(joint_out)
			&& $stable(gait_phase_out) && $stable(gait_started)))
		else $error("result beat changed while stalled");

	// The queue fills only through accepted pushes.
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// Results carry a real joint and a torque inside the widest clamp.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (joint_out <= JOINT_LAST && torque <= 25'sd16773120
			&& torque >= -25'sd16773120))
		else $error("result out of range");

	// Before the first tick the phase reads as zero.
	a_phase_before_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !gait_started) |-> (gait_phase_out == 2'd0))
		else $error("nonzero phase before gait start");

endmodule

bind biped_gait_pd_controller_unit gpd_checker u_gpd_checker (.*);
